### src/rme_pkg.sv
// rme_pkg: shared types, register indexes and the generator row-order table
// for the reed-muller encoder; no dependencies
`timescale 1ns / 1ps

package rme_pkg;

    localparam int MAX_VARS  = 6;
    localparam int CW_BITS   = 64;
    localparam int CFG_BITS  = 3;
    localparam int LEN_BITS  = 7;

    // configuration register indexes
    typedef enum logic {
        CFG_CODE_ORDER = 1'b0,
        CFG_NUM_VARS   = 1'b1
    } t_cfg_idx;

    // item moving between pipeline stages: working vector plus clamped m
    typedef struct packed {
        logic [CW_BITS-1:0]  vec;
        logic [CFG_BITS-1:0] m;
    } t_stage;

    // row index of each variable subset, per m: [m][subset mask]
    typedef logic [7:0][CW_BITS-1:0][5:0] t_idx_tab;

    function automatic int pop6(input int v);
        int c;
        c = 0;
        for (int b = 0; b < MAX_VARS; b++) begin
            if (((v >> b) & 1) != 0) c++;
        end
        return c;
    endfunction

    // rows ordered by subset size, then lexicographically; within one size
    // a subset comes first when the lowest differing variable belongs to it
    function automatic t_idx_tab build_idx_tab();
        t_idx_tab tab;
        int       cnt;
        int       d;
        int       low;
        tab = '0;
        for (int mm = 1; mm <= MAX_VARS; mm++) begin
            for (int s = 0; s < (1 << mm); s++) begin
                cnt = 0;
                for (int t = 0; t < (1 << mm); t++) begin
                    if (pop6(t) < pop6(s)) begin
                        cnt++;
                    end else if (pop6(t) == pop6(s) && t != s) begin
                        d   = t ^ s;
                        low = d & (~d + 1);
                        if ((t & low) != 0) cnt++;
                    end
                end
                tab[mm][s] = 6'(cnt);
            end
        end
        return tab;
    endfunction

    localparam t_idx_tab ROW_IDX = build_idx_tab();

endpackage

### src/reed_muller_encoder_unit.sv
// reed_muller_encoder_unit: top level of the RM(r,m) encoder; holds the
// configuration registers; depends on rme_pkg, rme_gather, rme_zeta_lo/hi
`timescale 1ns / 1ps

// usage
//   configuration: i_cfg_we writes i_cfg_data into the register chosen by
//   i_cfg_idx (0 code order, 1 number of variables); write only while no
//   item is in flight
//   input channel: one message item per i_valid && !o_stall edge; bit i of
//   i_message_bits feeds generator row i, bits at k and above are ignored
//   output channel: o_codeword and o_code_length are taken on
//   o_valid && !i_stall; codeword bits at n and above read as zero
//   pipeline: an accepted item is registered in turn in the input register,
//   the gather stage and two transform stages of three variables each;
//   o_valid is the valid flag of the last transform stage
//   throughput: one item per cycle while i_stall is low; four register stages
//   stalls: each stage holds its item while the next one is full and
//   stalled; an empty stage keeps taking items, so bubbles are squeezed out
//   reset: pipeline emptied, code order 1, three variables

module reed_muller_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rme_pkg::CFG_BITS-1:0]  i_cfg_data,
    // message channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rme_pkg::CW_BITS-1:0]   i_message_bits,
    // codeword channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rme_pkg::CW_BITS-1:0]   o_codeword,
    output logic [rme_pkg::LEN_BITS-1:0]  o_code_length
);

    logic [rme_pkg::CFG_BITS-1:0] r_code_order;
    logic [rme_pkg::CFG_BITS-1:0] r_num_vars;
    logic [rme_pkg::CFG_BITS-1:0] w_m;
    logic [rme_pkg::CFG_BITS-1:0] w_r;

    rme_pkg::t_stage w_gath_item;
    logic            w_gath_valid;
    logic            w_lo_stall;
    rme_pkg::t_stage w_lo_item;
    logic            w_lo_valid;
    logic            w_hi_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_order <= rme_pkg::CFG_BITS'(1);
            r_num_vars   <= rme_pkg::CFG_BITS'(3);
        end else if (i_cfg_we) begin
            case (rme_pkg::t_cfg_idx'(i_cfg_idx))
                rme_pkg::CFG_CODE_ORDER: r_code_order <= i_cfg_data;
                rme_pkg::CFG_NUM_VARS:   r_num_vars   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // m clamped to 1..MAX_VARS, r clamped to at most m
    always_comb begin
        w_m = r_num_vars;
        if (r_num_vars == '0) w_m = rme_pkg::CFG_BITS'(1);
        if (r_num_vars > rme_pkg::CFG_BITS'(rme_pkg::MAX_VARS))
            w_m = rme_pkg::CFG_BITS'(rme_pkg::MAX_VARS);
        w_r = (r_code_order > w_m) ? w_m : r_code_order;
    end

    rme_gather u_gather (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_bits (i_message_bits),
        .i_m            (w_m),
        .i_r            (w_r),
        .o_valid        (w_gath_valid),
        .i_stall        (w_lo_stall),
        .o_item         (w_gath_item)
    );

    rme_zeta_lo u_zeta_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_gath_valid),
        .o_stall (w_lo_stall),
        .i_item  (w_gath_item),
        .o_valid (w_lo_valid),
        .i_stall (w_hi_stall),
        .o_item  (w_lo_item)
    );

    rme_zeta_hi u_zeta_hi (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_lo_valid),
        .o_stall       (w_hi_stall),
        .i_item        (w_lo_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_codeword    (o_codeword),
        .o_code_length (o_code_length)
    );

endmodule

### src/rme_gather.sv
// rme_gather: input register and coefficient gather stage; message bits are
// scattered to subset-mask positions; depends on rme_pkg
`timescale 1ns / 1ps

module rme_gather (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rme_pkg::CW_BITS-1:0]   i_message_bits,
    input  logic [rme_pkg::CFG_BITS-1:0]  i_m,
    input  logic [rme_pkg::CFG_BITS-1:0]  i_r,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rme_pkg::t_stage               o_item
);

    // stage 1: input register
    logic                          r_v1;
    logic [rme_pkg::CW_BITS-1:0]   r_msg;
    logic [rme_pkg::CFG_BITS-1:0]  r_m;
    logic [rme_pkg::CFG_BITS-1:0]  r_r;
    // stage 2: gathered coefficients
    logic                          r_v2;
    rme_pkg::t_stage               r_item;
    rme_pkg::t_stage               n_item;
    logic                          w_en1;
    logic                          w_en2;

    assign w_en2   = !r_v2 || !i_stall;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v2;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_msg <= i_message_bits;
            r_m   <= i_m;
            r_r   <= i_r;
        end
        if (w_en2 && r_v1) r_item <= n_item;
    end

    // coefficient of subset s is message bit at its row index, when the
    // subset lies inside the m variables and its size is at most r
    always_comb begin
        n_item.m = r_m;
        for (int s = 0; s < rme_pkg::CW_BITS; s++) begin
            n_item.vec[s] = r_msg[rme_pkg::ROW_IDX[r_m][s]]
                          && ((s >> r_m) == 0)
                          && (rme_pkg::pop6(s) <= int'(r_r));
        end
    end

endmodule

### src/rme_zeta_lo.sv
// rme_zeta_lo: subset-sum transform over variables 0 to 2, one register
// stage; depends on rme_pkg
`timescale 1ns / 1ps

module rme_zeta_lo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rme_pkg::t_stage  i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output rme_pkg::t_stage  o_item
);

    logic            r_v;
    rme_pkg::t_stage r_item;
    rme_pkg::t_stage n_item;
    logic            w_en;

    assign w_en    = !r_v || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) r_item <= n_item;
    end

    // butterfly passes: g[u] ^= g[u without v] for u holding v
    always_comb begin
        n_item = i_item;
        for (int v = 0; v < 3; v++) begin
            for (int u = 0; u < rme_pkg::CW_BITS; u++) begin
                if (((u >> v) & 1) != 0) begin
                    n_item.vec[u] = n_item.vec[u] ^ n_item.vec[u ^ (1 << v)];
                end
            end
        end
    end

endmodule

### src/rme_zeta_hi.sv
// rme_zeta_hi: subset-sum transform over variables 3 to 5, then codeword
// bit reversal and length masking; depends on rme_pkg
`timescale 1ns / 1ps

module rme_zeta_hi (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rme_pkg::t_stage               i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rme_pkg::CW_BITS-1:0]   o_codeword,
    output logic [rme_pkg::LEN_BITS-1:0]  o_code_length
);

    logic                          r_v;
    logic [rme_pkg::CW_BITS-1:0]   r_cw;
    logic [rme_pkg::LEN_BITS-1:0]  r_len;
    logic [rme_pkg::CW_BITS-1:0]   w_g;
    logic [rme_pkg::CW_BITS-1:0]   n_cw;
    logic                          w_en;

    assign w_en          = !r_v || !i_stall;
    assign o_stall       = !w_en;
    assign o_valid       = r_v;
    assign o_codeword    = r_cw;
    assign o_code_length = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_cw  <= n_cw;
            r_len <= rme_pkg::LEN_BITS'(1) << i_item.m;
        end
    end

    // position j takes the sum over subsets disjoint from j, i.e. g[~j]
    always_comb begin
        w_g = i_item.vec;
        for (int v = 3; v < rme_pkg::MAX_VARS; v++) begin
            for (int u = 0; u < rme_pkg::CW_BITS; u++) begin
                if (((u >> v) & 1) != 0) begin
                    w_g[u] = w_g[u] ^ w_g[u ^ (1 << v)];
                end
            end
        end
        for (int j = 0; j < rme_pkg::CW_BITS; j++) begin
            n_cw[j] = w_g[rme_pkg::CW_BITS-1-j] && ((j >> i_item.m) == 0);
        end
    end

endmodule
